@@ src/imuafp_pkg.sv @@
// Shared constants for the IMU angle frame parser.
`default_nettype none

package imuafp_pkg;

    localparam logic [7:0] HEADER_BYTE     = 8'h55;
    localparam logic [7:0] FRAME_TYPE_RST  = 8'h53;

    // Frame byte positions
    localparam logic [3:0] POS_HEADER  = 4'd0;
    localparam logic [3:0] POS_TYPE    = 4'd1;
    localparam logic [3:0] POS_PITCH_L = 4'd2;
    localparam logic [3:0] POS_PITCH_H = 4'd3;
    localparam logic [3:0] POS_ROLL_L  = 4'd4;
    localparam logic [3:0] POS_ROLL_H  = 4'd5;
    localparam logic [3:0] POS_YAW_L   = 4'd6;
    localparam logic [3:0] POS_YAW_H   = 4'd7;
    localparam logic [3:0] POS_CHKSUM  = 4'd10;

    // Register map
    localparam int          ADDR_W        = 3;
    localparam int          DATA_W        = 32;
    localparam logic        REG_FRAME_TYPE = 1'b0;

    typedef logic [7:0]         t_byte;
    typedef logic signed [15:0] t_angle;

endpackage

`default_nettype wire

@@ src/imu_angle_frame_parser.sv @@
// IMU angle frame parser: byte input register, frame assembly, result register.
//
// Input channel (i_valid / o_ready / i_rx_byte) takes one serial byte per beat.
// Bytes are assembled into an 11-byte angle frame: 0x55 header, frame type
// (register frame_type at byte address 0), pitch, roll and yaw little-endian
// words, two unused bytes and an additive checksum over bytes 0..9.
// A bad header or type byte drops the byte and restarts the frame search.
// Output channel (o_valid / i_ready) gives one result beat per complete frame:
// o_status (1 = checksum mismatch, angles then forced to zero), o_pitch,
// o_roll and o_yaw.
// A checksum byte passes through the input register, then the result register,
// before its result shows up on the outputs.
// Throughput: one byte per cycle unless a result is stalled; the frame assembly
// logic sits between the two registers and handles a byte every cycle it is not held.
// When the receiver stalls with a result pending, bytes keep flowing until a
// checksum byte reaches the assembly stage; that byte then waits in the input
// register and o_ready drops until the result register frees up.
// Reset (synchronous, active low) clears the frame state, both valid flags and
// sets frame_type to 0x53. The APB port has no wait states.
`default_nettype none

module imu_angle_frame_parser (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // byte input
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  imuafp_pkg::t_byte       i_rx_byte,
    // result output
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic                          o_status,
    output imuafp_pkg::t_angle            o_pitch,
    output imuafp_pkg::t_angle            o_roll,
    output logic [15:0]                   o_yaw,
    // configuration
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [imuafp_pkg::ADDR_W-1:0] paddr,
    input  wire  [imuafp_pkg::DATA_W-1:0] pwdata,
    output logic [imuafp_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);
    import imuafp_pkg::*;

    // configuration
    t_byte       r_frame_type;
    logic        w_cfg_wr;

    // input register
    logic        r_in_valid;
    t_byte       r_in_byte;

    // frame state
    logic [3:0]  r_count,    n_count;
    t_byte       r_sum,      n_sum;
    t_byte       r_low,      n_low;
    logic [15:0] r_pitch_w,  n_pitch_w;
    logic [15:0] r_roll_w,   n_roll_w;
    logic [15:0] r_yaw_w,    n_yaw_w;

    // result register
    logic        r_out_valid;
    logic        r_status,   n_status;
    logic [15:0] r_pitch,    n_pitch;
    logic [15:0] r_roll,     n_roll;
    logic [15:0] r_yaw,      n_yaw;

    logic [3:0]  w_pos;
    logic        w_is_last;
    logic        w_out_free;
    logic        w_proc;
    logic        w_bad;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_TYPE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_type <= FRAME_TYPE_RST;
        end else if (w_cfg_wr) begin
            r_frame_type <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FRAME_TYPE) begin
            prdata = {{(DATA_W-8){1'b0}}, r_frame_type};
        end
    end

    // ---------------- handshake ----------------
    // out-of-range count behaves as position 0
    assign w_pos      = (r_count > POS_CHKSUM) ? POS_HEADER : r_count;
    assign w_is_last  = (w_pos == POS_CHKSUM);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_proc     = r_in_valid && (!w_is_last || w_out_free);
    assign o_ready    = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // ---------------- frame assembly ----------------
    assign w_bad = (r_sum != r_in_byte);

    always_comb begin
        n_count   = w_pos + 4'd1;
        n_sum     = r_sum + r_in_byte;
        n_low     = r_low;
        n_pitch_w = r_pitch_w;
        n_roll_w  = r_roll_w;
        n_yaw_w   = r_yaw_w;
        n_status  = w_bad;
        n_pitch   = w_bad ? 16'd0 : r_pitch_w;
        n_roll    = w_bad ? 16'd0 : r_roll_w;
        n_yaw     = w_bad ? 16'd0 : r_yaw_w;
        case (w_pos)
            POS_HEADER: begin
                n_sum = r_in_byte;
                if (r_in_byte != HEADER_BYTE) begin
                    n_count = POS_HEADER;
                    n_sum   = r_sum;
                end
            end
            POS_TYPE: begin
                // no resync: a bad type byte is simply dropped
                if (r_in_byte != r_frame_type) begin
                    n_count = POS_HEADER;
                    n_sum   = r_sum;
                end
            end
            POS_PITCH_L, POS_ROLL_L, POS_YAW_L: n_low = r_in_byte;
            POS_PITCH_H: n_pitch_w = {r_in_byte, r_low};
            POS_ROLL_H:  n_roll_w  = {r_in_byte, r_low};
            POS_YAW_H:   n_yaw_w   = {r_in_byte, r_low};
            POS_CHKSUM: begin
                n_count = POS_HEADER;
                n_sum   = r_sum;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_low     <= '0;
            r_pitch_w <= '0;
            r_roll_w  <= '0;
            r_yaw_w   <= '0;
        end else if (w_proc) begin
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_low     <= n_low;
            r_pitch_w <= n_pitch_w;
            r_roll_w  <= n_roll_w;
            r_yaw_w   <= n_yaw_w;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && w_is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_is_last) begin
            r_status <= n_status;
            r_pitch  <= n_pitch;
            r_roll   <= n_roll;
            r_yaw    <= n_yaw;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_pitch  = r_pitch;
    assign o_roll   = r_roll;
    assign o_yaw    = r_yaw;

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= POS_CHKSUM)
        else $error("frame byte count out of range");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && w_is_last))
        else $error("result without a checksum byte");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status) |-> (r_pitch == 16'd0 && r_roll == 16'd0 && r_yaw == 16'd0))
        else $error("angles not cleared on checksum mismatch");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_is_last && r_out_valid && !i_ready) |=> (r_in_valid && r_out_valid))
        else $error("checksum byte lost during output stall");

endmodule

`default_nettype wire
